// ===== sv/u8mr_pkg.sv =====
// ----------------------------------------------------------------------------
// u8mr_pkg
// shared types, constants and the reverse table lookup for the transcoder
// ----------------------------------------------------------------------------
package u8mr_pkg;

    localparam int CP_W    = 21;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic            err;
        logic [CP_W-1:0] cp;
    } t_q_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] idx;
    } t_lookup;

    // upper half of the table, entries 0x80 to 0xff
    localparam logic [15:0] MAC_HI [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    function automatic t_lookup mac_lookup(input logic [CP_W-1:0] cp);
        t_lookup r;
        r.hit = 1'b0;
        r.idx = 8'h00;
        if (cp[CP_W-1:7] == '0) begin
            r.hit = 1'b1;
            r.idx = {1'b0, cp[6:0]};
        end else if (cp[CP_W-1:16] == '0) begin
            for (int k = 0; k < 128; k++) begin
                if (cp[15:0] == MAC_HI[k]) begin
                    r.hit = 1'b1;
                    r.idx = {1'b1, 7'(k)};
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/u8mr_front.sv =====
// ----------------------------------------------------------------------------
// u8mr_front
// utf-8 sequence decoder: classifies lead bytes and builds code points
// ----------------------------------------------------------------------------
module u8mr_front import u8mr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    [7:0] i_in_byte,
    input  logic    i_q_full,
    output logic    o_q_wr,
    output t_q_item o_q_item
);

    logic [1:0]      r_pending, n_pending;
    logic [CP_W-1:0] r_accum, n_accum;
    logic            accept;

    assign accept = i_push && !i_q_full;

    always_comb begin
        n_pending = r_pending;
        n_accum   = r_accum;
        o_q_wr    = 1'b0;
        o_q_item  = '{err: 1'b0, cp: '0};
        if (accept) begin
            if (r_pending != 2'd0) begin
                n_accum   = {r_accum[CP_W-7:0], i_in_byte[5:0]};
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    o_q_wr   = 1'b1;
                    o_q_item = '{err: 1'b0, cp: n_accum};
                end
            end else if (i_in_byte[7] == 1'b0) begin
                n_accum  = {{(CP_W-7){1'b0}}, i_in_byte[6:0]};
                o_q_wr   = 1'b1;
                o_q_item = '{err: 1'b0, cp: n_accum};
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_accum   = {{(CP_W-5){1'b0}}, i_in_byte[4:0]};
                n_pending = 2'd1;
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_accum   = {{(CP_W-4){1'b0}}, i_in_byte[3:0]};
                n_pending = 2'd2;
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_accum   = {{(CP_W-3){1'b0}}, i_in_byte[2:0]};
                n_pending = 2'd3;
            end else begin
                o_q_wr   = 1'b1;
                o_q_item = '{err: 1'b1, cp: '0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_accum   <= '0;
        end else begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

endmodule

// ===== sv/u8mr_queue.sv =====
// ----------------------------------------------------------------------------
// u8mr_queue
// short register queue between the decoder and the table lookup
// ----------------------------------------------------------------------------
module u8mr_queue import u8mr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_q_item i_wr_item,
    input  logic    i_rd,
    output t_q_item o_head,
    output logic    o_empty,
    output logic    o_full
);

    t_q_item         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            do_wr, do_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/u8mr_back.sv =====
// ----------------------------------------------------------------------------
// u8mr_back
// reverse table lookup and registered result stage
// ----------------------------------------------------------------------------
module u8mr_back import u8mr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_item i_head,
    input  logic    i_q_empty,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output logic    [7:0] o_mac_byte,
    output logic    o_status
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_status, n_status;
    t_lookup    lk;

    assign lk     = mac_lookup(i_head.cp);
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_comb begin
        n_valid  = r_valid;
        n_byte   = r_byte;
        n_status = r_status;
        if (o_q_rd) begin
            n_valid  = i_head.err || lk.hit;
            n_byte   = i_head.err ? 8'h00 : lk.idx;
            n_status = i_head.err;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_status <= n_status;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_empty    = !r_valid;
    assign o_mac_byte = r_byte;
    assign o_status   = r_status;

endmodule

// ===== sv/utf8_to_mac_roman_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_mac_roman_core
// Takes one raw UTF-8 byte per cycle and gives the MacRoman byte of each
// completed code point. Code points with no MacRoman entry give no result;
// a stray continuation byte or a lead byte 0xf8-0xff in lead position gives
// one result with status 1 and mac_byte 0. Bytes after a lead byte are taken
// on their low six bits without a tag check. A new byte is accepted every
// cycle while full is low; a completed code point passes through the
// four-entry decoder queue and then the result register, and the result
// register is refilled in the cycle it is popped.
// ----------------------------------------------------------------------------
module utf8_to_mac_roman_core import u8mr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_mac_byte,
    output logic       o_status
);

    logic    q_wr, q_rd, q_empty, q_full;
    t_q_item q_wr_item, q_head;

    assign full = q_full;

    u8mr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_q_full  (q_full),
        .o_q_wr    (q_wr),
        .o_q_item  (q_wr_item)
    );

    u8mr_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_item (q_wr_item),
        .i_rd      (q_rd),
        .o_head    (q_head),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    u8mr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_empty  (q_empty),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_mac_byte (o_mac_byte),
        .o_status   (o_status)
    );

endmodule

// ===== sv/u8mr_checker.sv =====
// ----------------------------------------------------------------------------
// u8mr_checker
// port-level checks of the transcoder, bound to the top level
// ----------------------------------------------------------------------------
module u8mr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_mac_byte,
    input logic       o_status
);

    // error results carry a zero byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status) |-> (o_mac_byte == 8'h00))
        else $error("error result with nonzero byte");

    // nothing waits right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full flag after reset");

    // full only rises after an accepted request
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_mac_byte) && $stable(o_status)))
        else $error("waiting result changed");

endmodule

bind utf8_to_mac_roman_core u8mr_checker u_chk (.*);
